FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define BCHT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bcht assertion failed");

// check that a condition in one cycle implies another in the next
`define BCHT_ASSERT_NEXT(label, pre, post) \
  `BCHT_ASSERT(label, (pre) |=> (post))

`endif

FILE: hw/rtl/bcht_pkg.sv
// ----------------------------------------------------------------------------
// bcht_pkg
// Types, codes and hash constants of the bucketed cuckoo hash table.
// ----------------------------------------------------------------------------
package bcht_pkg;

  localparam int unsigned KEY_BITS  = 64;
  localparam int unsigned DATA_BITS = 32;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_UPDATED  = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  localparam logic [63:0] MIX_ADD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_M1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_M2  = 64'h94D049BB133111EB;

  typedef struct packed {
    logic [1:0]           op;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [DATA_BITS-1:0] found_value;
    logic [KEY_BITS-1:0]  spill_key;
    logic [DATA_BITS-1:0] spill_value;
  } rsp_t;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_LOAD,
    STEP_HASH,
    STEP_POS_INIT,
    STEP_POS_NEXT,
    STEP_RD_B1,
    STEP_RD_B2,
    STEP_RD_POS,
    STEP_PROBE,
    STEP_MISS,
    STEP_KICK,
    STEP_CLR_ROW
  } dp_step_e;

  typedef struct packed {
    dp_step_e step;
    logic     present;
  } cmd_t;

  typedef struct packed {
    logic       hash_done;
    logic       hit;
    logic       free;
    logic       kick_last;
    logic       row_last;
    logic [1:0] op;
  } sts_t;

endpackage

FILE: hw/rtl/bcht_ram.sv
// ----------------------------------------------------------------------------
// bcht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bcht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bcht_hash.sv
// ----------------------------------------------------------------------------
// bcht_hash
// Multi-cycle key mixer on one shared 32x32 multiplier, with bucket selection
// by a constant reciprocal when NESTS is not a power of two.
// ----------------------------------------------------------------------------
module bcht_hash import bcht_pkg::*; #(
  parameter int unsigned NESTS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [KEY_BITS-1:0]      salt_i,
  output logic                     done_o,
  output logic [$clog2(NESTS)-1:0] b1_o,
  output logic [$clog2(NESTS)-1:0] b2_o
);

  localparam int unsigned NB    = $clog2(NESTS);
  localparam bit          POW2  = ((NESTS & (NESTS - 1)) == 0);
  localparam int unsigned SH    = 31 + NB;
  localparam logic [63:0] RCP   = (64'd1 << SH) / 64'(NESTS);

  logic        run_q, modr_q, done_q;
  logic [2:0]  ph_q;
  logic [1:0]  mc_q;
  logic [63:0] a_q, p_q, acc_q, h_q;
  logic [NB-1:0] r1_q, r2_q;
  logic [31:0] q_q, xsel;

  logic [63:0] z0, mb_full, mul, nacc, hval;
  logic [63:0] qprod, qsh, qn, rdiff, rfix;
  logic [31:0] ma, mb;

  assign z0      = (key_i ^ salt_i) + MIX_ADD;
  assign ma      = (ph_q[1:0] == 2'd1) ? a_q[63:32] : a_q[31:0];
  assign mb_full = ph_q[2] ? MIX_M2 : MIX_M1;
  assign mb      = (ph_q[1:0] == 2'd2) ? mb_full[63:32] : mb_full[31:0];
  assign mul     = 64'(ma) * 64'(mb);
  assign nacc    = {acc_q[63:32] + p_q[31:0], acc_q[31:0]};
  assign hval    = nacc ^ (nacc >> 31);

  assign xsel  = mc_q[1] ? h_q[63:32] : h_q[31:0];
  assign qprod = 64'(xsel) * 64'(RCP[31:0]);
  assign qsh   = qprod >> SH;
  assign qn    = 64'(q_q) * 64'(NESTS);
  assign rdiff = 64'(xsel) - qn;
  assign rfix  = (rdiff >= 64'(NESTS)) ? rdiff - 64'(NESTS) : rdiff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      modr_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
      mc_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= '0;
      end else if (run_q) begin
        ph_q <= ph_q + 3'd1;
        if (ph_q == 3'd7) begin
          run_q <= 1'b0;
          if (POW2) begin
            done_q <= 1'b1;
          end else begin
            modr_q <= 1'b1;
            mc_q   <= '0;
          end
        end
      end else if (modr_q) begin
        mc_q <= mc_q + 2'd1;
        if (mc_q == 2'd3) begin
          modr_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= z0 ^ (z0 >> 30);
    end else if (run_q) begin
      unique case (ph_q[1:0])
        2'd0: begin
          p_q <= mul;
        end
        2'd1: begin
          acc_q <= p_q;
          p_q   <= mul;
        end
        2'd2: begin
          acc_q[63:32] <= acc_q[63:32] + p_q[31:0];
          p_q          <= mul;
        end
        default: begin
          if (!ph_q[2]) begin
            a_q <= nacc ^ (nacc >> 27);
          end else if (POW2) begin
            r1_q <= hval[NB-1:0];
            r2_q <= hval[32 +: NB];
          end else begin
            h_q <= hval;
          end
        end
      endcase
    end else if (modr_q) begin
      if (!mc_q[0]) begin
        q_q <= qsh[31:0];
      end else if (!mc_q[1]) begin
        r1_q <= rfix[NB-1:0];
      end else begin
        r2_q <= rfix[NB-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign b1_o   = r1_q;
  assign b2_o   = r2_q;

endmodule

FILE: hw/rtl/bcht_dp.sv
// ----------------------------------------------------------------------------
// bcht_dp
// Datapath: bucket memories, hash unit, working entry and result registers.
// ----------------------------------------------------------------------------
module bcht_dp import bcht_pkg::*; #(
  parameter int unsigned NESTS      = 256,
  parameter int unsigned SLOTS      = 4,
  parameter int unsigned MAX_KICKS  = 6,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  req_t                req_i,
  input  logic [KEY_BITS-1:0] salt_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output rsp_t                rsp_o
);

  localparam int unsigned NB = $clog2(NESTS);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KW = (MAX_KICKS > 1) ? $clog2(MAX_KICKS) : 1;

  logic [1:0]            op_q;
  logic [KEY_BITS-1:0]   ck_q;
  logic [VALUE_BITS-1:0] cv_q;
  logic [NB-1:0]         pos_q, rrow_q, row_q, raddr, waddr_f;
  logic [SW-1:0]         eject_q, hit_i, free_i, sel;
  logic [KW-1:0]         tries_q;
  rsp_t                  res_q, res_d, out_q;

  logic                  hash_done, hit, free, kick_last, row_last, rd_en;
  logic                  we_k, we_v, we_f;
  logic [NB-1:0]         hb1, hb2;

  logic [SLOTS-1:0][KEY_BITS-1:0]   krow_r, krow_w;
  logic [SLOTS-1:0][VALUE_BITS-1:0] vrow_r, vrow_w;
  logic [SLOTS-1:0]                 vld_r, vld_w, vld_wd;

  bcht_hash #(.NESTS(NESTS)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.step == STEP_HASH),
    .key_i   (ck_q),
    .salt_i  (salt_i),
    .done_o  (hash_done),
    .b1_o    (hb1),
    .b2_o    (hb2)
  );

  assign rd_en = (cmd_i.step == STEP_RD_B1) || (cmd_i.step == STEP_RD_B2) ||
                 (cmd_i.step == STEP_RD_POS);
  assign raddr = (cmd_i.step == STEP_RD_B1) ? hb1 :
                 (cmd_i.step == STEP_RD_B2) ? hb2 : pos_q;

  assign we_k    = (cmd_i.step == STEP_KICK);
  assign we_v    = we_k || ((cmd_i.step == STEP_PROBE) && (op_q == OP_INSERT));
  assign we_f    = (cmd_i.step == STEP_CLR_ROW) ||
                   ((cmd_i.step == STEP_PROBE) && (op_q == OP_REMOVE)) ||
                   ((cmd_i.step == STEP_KICK) && free);
  assign waddr_f = (cmd_i.step == STEP_CLR_ROW) ? row_q : rrow_q;
  assign vld_wd  = (cmd_i.step == STEP_CLR_ROW) ? '0 : vld_w;

  bcht_ram #(.WIDTH(SLOTS * KEY_BITS), .DEPTH(NESTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we_k),
    .waddr_i (rrow_q),
    .wdata_i (krow_w),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (krow_r)
  );

  bcht_ram #(.WIDTH(SLOTS * VALUE_BITS), .DEPTH(NESTS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (we_v),
    .waddr_i (rrow_q),
    .wdata_i (vrow_w),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (vrow_r)
  );

  bcht_ram #(.WIDTH(SLOTS), .DEPTH(NESTS)) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (we_f),
    .waddr_i (waddr_f),
    .wdata_i (vld_wd),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (vld_r)
  );

  always_comb begin
    hit    = 1'b0;
    hit_i  = '0;
    free   = 1'b0;
    free_i = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vld_r[i] && (krow_r[i] == ck_q)) begin
        hit   = 1'b1;
        hit_i = SW'(i);
      end
      if (!vld_r[i]) begin
        free   = 1'b1;
        free_i = SW'(i);
      end
    end
  end

  assign kick_last = (tries_q == KW'(MAX_KICKS - 1));
  assign row_last  = (row_q == NB'(NESTS - 1));
  assign sel       = free ? free_i : eject_q;

  always_comb begin
    krow_w = krow_r;
    vrow_w = vrow_r;
    vld_w  = vld_r;
    if (cmd_i.step == STEP_PROBE) begin
      vld_w[hit_i]  = 1'b0;
      vrow_w[hit_i] = cv_q;
    end else begin
      krow_w[sel] = ck_q;
      vrow_w[sel] = cv_q;
      vld_w[sel]  = 1'b1;
    end
  end

  always_comb begin
    res_d = res_q;
    unique case (cmd_i.step)
      STEP_PROBE: begin
        res_d = '0;
        unique case (op_q)
          OP_LOOKUP: begin
            res_d.status      = ST_HIT;
            res_d.found_value = DATA_BITS'(vrow_r[hit_i]);
          end
          OP_REMOVE: res_d.status = ST_REMOVED;
          default:   res_d.status = ST_UPDATED;
        endcase
      end
      STEP_MISS: begin
        res_d        = '0;
        res_d.status = ST_MISS;
      end
      STEP_KICK: begin
        if (free) begin
          res_d        = '0;
          res_d.status = ST_INSERTED;
        end else if (kick_last) begin
          res_d             = '0;
          res_d.status      = ST_FULL;
          res_d.spill_key   = krow_r[eject_q];
          res_d.spill_value = DATA_BITS'(vrow_r[eject_q]);
        end
      end
      STEP_CLR_ROW: begin
        res_d        = '0;
        res_d.status = ST_CLEARED;
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      eject_q <= '0;
      tries_q <= '0;
    end else begin
      if (cmd_i.step == STEP_LOAD) begin
        row_q   <= '0;
        eject_q <= '0;
        tries_q <= '0;
      end else if (cmd_i.step == STEP_CLR_ROW) begin
        row_q <= row_last ? '0 : row_q + NB'(1);
      end else if ((cmd_i.step == STEP_KICK) && !free) begin
        eject_q <= (eject_q == SW'(SLOTS - 1)) ? '0 : eject_q + SW'(1);
        tries_q <= tries_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.present) begin
      out_q <= res_q;
    end
    if (rd_en) begin
      rrow_q <= raddr;
    end
    if (cmd_i.step == STEP_LOAD) begin
      op_q <= req_i.op;
      ck_q <= req_i.key;
      cv_q <= VALUE_BITS'(req_i.value);
    end else if ((cmd_i.step == STEP_KICK) && !free) begin
      ck_q <= krow_r[eject_q];
      cv_q <= vrow_r[eject_q];
    end
    if (cmd_i.step == STEP_POS_INIT) begin
      pos_q <= hb1;
    end else if (cmd_i.step == STEP_POS_NEXT) begin
      pos_q <= (pos_q == hb1) ? hb2 : hb1;
    end
  end

  assign sts_o = '{hash_done: hash_done, hit: hit, free: free, kick_last: kick_last,
                   row_last: row_last, op: op_q};
  assign rsp_o = out_q;

endmodule

FILE: hw/rtl/bcht_ctrl.sv
// ----------------------------------------------------------------------------
// bcht_ctrl
// Operation sequencer: probe, kick loop, clear sweep and result handoff.
// ----------------------------------------------------------------------------
module bcht_ctrl import bcht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HSTART = 4'd2;
  localparam logic [3:0] S_HWAIT  = 4'd3;
  localparam logic [3:0] S_RD1    = 4'd4;
  localparam logic [3:0] S_CK1    = 4'd5;
  localparam logic [3:0] S_RD2    = 4'd6;
  localparam logic [3:0] S_CK2    = 4'd7;
  localparam logic [3:0] S_KRD    = 4'd8;
  localparam logic [3:0] S_KCK    = 4'd9;
  localparam logic [3:0] S_KHS    = 4'd10;
  localparam logic [3:0] S_KHW    = 4'd11;
  localparam logic [3:0] S_KPOS   = 4'd12;
  localparam logic [3:0] S_CLR    = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.step    = STEP_IDLE;
    cmd_o.present = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.step = STEP_CLR_ROW;
        if (sts_i.row_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = STEP_LOAD;
          state_d    = S_HSTART;
        end
      end
      S_HSTART: begin
        if (sts_i.op == OP_CLEAR) begin
          cmd_o.step = STEP_CLR_ROW;
          state_d    = sts_i.row_last ? S_DONE : S_CLR;
        end else begin
          cmd_o.step = STEP_HASH;
          state_d    = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (sts_i.hash_done) state_d = S_RD1;
      end
      S_RD1: begin
        cmd_o.step = STEP_RD_B1;
        state_d    = S_CK1;
      end
      S_CK1: begin
        if (sts_i.hit) begin
          cmd_o.step = STEP_PROBE;
          state_d    = S_DONE;
        end else begin
          state_d = S_RD2;
        end
      end
      S_RD2: begin
        cmd_o.step = STEP_RD_B2;
        state_d    = S_CK2;
      end
      S_CK2: begin
        if (sts_i.hit) begin
          cmd_o.step = STEP_PROBE;
          state_d    = S_DONE;
        end else if (sts_i.op == OP_INSERT) begin
          cmd_o.step = STEP_POS_INIT;
          state_d    = S_KRD;
        end else begin
          cmd_o.step = STEP_MISS;
          state_d    = S_DONE;
        end
      end
      S_KRD: begin
        cmd_o.step = STEP_RD_POS;
        state_d    = S_KCK;
      end
      S_KCK: begin
        cmd_o.step = STEP_KICK;
        state_d    = (sts_i.free || sts_i.kick_last) ? S_DONE : S_KHS;
      end
      S_KHS: begin
        cmd_o.step = STEP_HASH;
        state_d    = S_KHW;
      end
      S_KHW: begin
        if (sts_i.hash_done) state_d = S_KPOS;
      end
      S_KPOS: begin
        cmd_o.step = STEP_POS_NEXT;
        state_d    = S_KRD;
      end
      S_CLR: begin
        cmd_o.step = STEP_CLR_ROW;
        if (sts_i.row_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.present = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.present) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/bucketed_cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// bucketed_cuckoo_hash_table
// Two-choice bucketized cuckoo key-value store with eviction and clear.
//
//   channel  signals                         direction
//   request  in_valid_i / in_ready_o, req_i  in
//   response out_valid_o / out_ready_i, rsp_o out
//   salt     cfg_we_i, cfg_wdata_i           in
//
// Each hash runs on the shared multiplier, then a reciprocal remainder
// computation forms both buckets when NESTS is not a power of two. A lookup,
// remove or update ends at its first bucket when the key sits there and
// reads the second otherwise; an insert of a new key goes on to eviction
// rounds, each adding one hash. Clear sweeps one bucket row a cycle. After
// reset a sweep clears the valid bits before in_ready_o rises. A held
// response stalls only the next handoff.
// ----------------------------------------------------------------------------
module bucketed_cuckoo_hash_table import bcht_pkg::*; #(
  parameter int unsigned NESTS      = 256,
  parameter int unsigned SLOTS      = 4,
  parameter int unsigned MAX_KICKS  = 6,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [KEY_BITS-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                rsp_o
);

  logic [KEY_BITS-1:0] salt_q;
  cmd_t                cmd;
  sts_t                sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q <= '0;
    end else if (cfg_we_i) begin
      salt_q <= cfg_wdata_i;
    end
  end

  bcht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcht_dp #(
    .NESTS      (NESTS),
    .SLOTS      (SLOTS),
    .MAX_KICKS  (MAX_KICKS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .salt_i (salt_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: hw/rtl/bcht_checker.sv
// ----------------------------------------------------------------------------
// bcht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcht_checker import bcht_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t rsp_o
);

  `BCHT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BCHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `BCHT_ASSERT(a_status_range, out_valid_o |-> (rsp_o.status <= ST_FULL))
  `BCHT_ASSERT(a_found_zero, out_valid_o && (rsp_o.status != ST_HIT) |-> (rsp_o.found_value == '0))
  `BCHT_ASSERT(a_spill_zero, out_valid_o && (rsp_o.status != ST_FULL) |-> (rsp_o.spill_key == '0))

endmodule

bind bucketed_cuckoo_hash_table bcht_checker u_checker (.*);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bucketed cuckoo hash table: directed, random
// request streams are checked against a behavioral copy of the table, salt
// changes between phases, responses compared field by field in order.
// ----------------------------------------------------------------------------
import bcht_pkg::*;

class cuckoo_scoreboard;
  localparam int NESTS_C = 256;
  localparam int SLOTS_C = 4;
  localparam int KICKS_C = 6;

  logic [63:0] salt;
  logic [63:0] tbl_key [NESTS_C*SLOTS_C];
  logic [31:0] tbl_val [NESTS_C*SLOTS_C];
  bit          tbl_vld [NESTS_C*SLOTS_C];
  rsp_t        pending [$];
  int          mismatches;

  function new();
    salt = '0;
    mismatches = 0;
    foreach (tbl_vld[i]) begin
      tbl_vld[i] = 0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
  endfunction

  function logic [63:0] mix(logic [63:0] x);
    logic [63:0] z;
    z = x + MIX_ADD;
    z = (z ^ (z >> 30)) * MIX_M1;
    z = (z ^ (z >> 27)) * MIX_M2;
    return z ^ (z >> 31);
  endfunction

  function void buckets(logic [63:0] k, output int b1, output int b2);
    logic [63:0] h;
    h = mix(k ^ salt);
    b1 = int'(h[31:0] % NESTS_C);
    b2 = int'(h[63:32] % NESTS_C);
  endfunction

  function int find(logic [63:0] k);
    int b1, b2;
    buckets(k, b1, b2);
    for (int i = 0; i < SLOTS_C; i++)
      if (tbl_vld[b1*SLOTS_C+i] && tbl_key[b1*SLOTS_C+i] == k) return b1*SLOTS_C+i;
    for (int i = 0; i < SLOTS_C; i++)
      if (tbl_vld[b2*SLOTS_C+i] && tbl_key[b2*SLOTS_C+i] == k) return b2*SLOTS_C+i;
    return -1;
  endfunction

  function void note_request(req_t r);
    rsp_t e;
    int ix, b1, b2, pos, eject, s;
    bit placed;
    logic [63:0] ck, tk;
    logic [31:0] cv, tv;
    e = '0;
    e.status = ST_MISS;
    case (r.op)
      OP_LOOKUP: begin
        ix = find(r.key);
        if (ix >= 0) begin
          e.status = ST_HIT;
          e.found_value = tbl_val[ix];
        end
      end
      OP_REMOVE: begin
        ix = find(r.key);
        if (ix >= 0) begin
          tbl_vld[ix] = 0;
          e.status = ST_REMOVED;
        end
      end
      OP_CLEAR: begin
        foreach (tbl_vld[i]) tbl_vld[i] = 0;
        e.status = ST_CLEARED;
      end
      default: begin
        ix = find(r.key);
        if (ix >= 0) begin
          tbl_val[ix] = r.value;
          e.status = ST_UPDATED;
        end else begin
          ck = r.key;
          cv = r.value;
          placed = 0;
          eject = 0;
          buckets(ck, b1, b2);
          pos = b1;
          for (int t = 0; t < KICKS_C && !placed; t++) begin
            for (int i = 0; i < SLOTS_C && !placed; i++) begin
              s = pos*SLOTS_C + i;
              if (!tbl_vld[s]) begin
                tbl_key[s] = ck;
                tbl_val[s] = cv;
                tbl_vld[s] = 1;
                placed = 1;
              end
            end
            if (!placed) begin
              s = pos*SLOTS_C + eject;
              tk = tbl_key[s];
              tv = tbl_val[s];
              tbl_key[s] = ck;
              tbl_val[s] = cv;
              ck = tk;
              cv = tv;
              eject = (eject + 1) % SLOTS_C;
              buckets(ck, b1, b2);
              pos = (pos == b1) ? b2 : b1;
            end
          end
          if (placed) e.status = ST_INSERTED;
          else begin
            e.status = ST_FULL;
            e.spill_key = ck;
            e.spill_value = cv;
          end
        end
      end
    endcase
    pending.push_back(e);
  endfunction

  function void check_response(rsp_t a);
    rsp_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response %h", a);
      return;
    end
    e = pending.pop_front();
    if (a.status !== e.status || a.found_value !== e.found_value ||
        a.spill_key !== e.spill_key || a.spill_value !== e.spill_value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st=%0d fv=%h sk=%h sv=%h  got st=%0d fv=%h sk=%h sv=%h",
                 e.status, e.found_value, e.spill_key, e.spill_value,
                 a.status, a.found_value, a.spill_key, a.spill_value);
    end
  endfunction
endclass

module tb_top;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  req_t        req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  rsp_t        rsp_o;

  cuckoo_scoreboard sb = new();
  int  idle_pct = 10;
  int  quiet_cycles = 0;
  logic [63:0] key_pool [16];

  localparam int QUIET_LIMIT = 20000;

  always #5 clk_i = ~clk_i;

  bucketed_cuckoo_hash_table DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .req_i(req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .rsp_o(rsp_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(req_i);
      if (out_valid_o && out_ready_i) sb.check_response(rsp_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send(logic [1:0] op, logic [63:0] key, logic [31:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    req_i <= '{op: op, key: key, value: value};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set_salt(logic [63:0] s);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= s;
    sb.salt = s;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(int n, int pool_bits);
    logic [1:0] op;
    int r;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) op = OP_INSERT;
      else if (r < 75) op = OP_LOOKUP;
      else if (r < 99) op = OP_REMOVE;
      else op = OP_CLEAR;
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range((1 << pool_bits) - 1)];
      else k = rand64();
      send(op, k, $urandom());
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    send(OP_LOOKUP, '0, '0);
    send(OP_REMOVE, '1, '0);
    send(OP_INSERT, '0, '0);
    send(OP_INSERT, '1, '1);
    send(OP_LOOKUP, '0, '0);
    send(OP_LOOKUP, '1, '0);
    send(OP_INSERT, '1, 32'h5A5A_A5A5);
    send(OP_LOOKUP, '1, '0);
    send(OP_REMOVE, '0, '0);
    send(OP_REMOVE, '0, '0);
    send(OP_LOOKUP, '0, '0);
    send(OP_CLEAR, '1, '1);
    send(OP_LOOKUP, '1, '0);
    for (int i = 0; i < 10; i++) send(OP_INSERT, rand64(), $urandom());
    drain_and_set_salt('1);
    idle_pct = 0;
    random_phase(200, 4);
    idle_pct = 10;
    random_phase(200, 4);
    drain_and_set_salt(rand64());
    for (int i = 0; i < 1100; i++) send(OP_INSERT, rand64(), $urandom());
    random_phase(100, 4);
    drain_and_set_salt('0);
    random_phase(200, 4);
    send(OP_CLEAR, '0, '0);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bcht_pkg.sv
hw/rtl/bcht_ram.sv
hw/rtl/bcht_hash.sv
hw/rtl/bcht_dp.sv
hw/rtl/bcht_ctrl.sv
hw/rtl/bucketed_cuckoo_hash_table.sv
hw/rtl/bcht_checker.sv
verif/tb_top.sv
